### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("%m: check failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

### rtl/core/ssms_pkg.sv
// Types, constants and helpers for the sonar sweep median/spread block.
package ssms_pkg;

    localparam int POS_W        = 2;
    localparam int NUM_POS      = 3;
    localparam int SAMPLE_COUNT = 3;
    localparam int RANGE_W      = 12;
    localparam int SPREAD_W     = 23;
    localparam int ANGLE_W      = 8;
    localparam int CFG_IDX_W    = 2;

    typedef logic [POS_W-1:0]     pos_t;
    typedef logic [1:0]           phase_t;
    typedef logic [ANGLE_W-1:0]   angle_t;
    typedef logic [RANGE_W-1:0]   range_t;
    typedef logic [SPREAD_W-1:0]  spread_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE_POS0 = 2'd0,
        CFG_ANGLE_POS1 = 2'd1,
        CFG_ANGLE_POS2 = 2'd2
    } cfg_reg_t;

    // Scan positions
    localparam pos_t POS_ZERO = 2'd0;
    localparam pos_t POS_ONE  = 2'd1;
    localparam pos_t POS_TWO  = 2'd2;

    // Phase that maps back to the middle position on the return sweep
    localparam phase_t PHASE_RETURN = 2'd3;

    // Servo angle defaults
    localparam angle_t ANGLE_POS0_RESET = 8'd120;
    localparam angle_t ANGLE_POS1_RESET = 8'd90;
    localparam angle_t ANGLE_POS2_RESET = 8'd60;

    // Ping-pong sweep: phases 0,1,2,3 visit positions 0,1,2,1
    function automatic pos_t phase_to_pos(phase_t ph);
        pos_t p;
        p = (ph == PHASE_RETURN) ? POS_ONE : pos_t'(ph);
        return p;
    endfunction

endpackage

### rtl/core/ssms_sample_if.sv
// Sample channel: three range samples per transaction.
interface ssms_sample_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_a;
    logic [SAMPLE_BITS-1:0] sample_b;
    logic [SAMPLE_BITS-1:0] sample_c;

    modport source (output valid, output sample_a, output sample_b, output sample_c,
                    input ready);
    modport sink   (input valid, input sample_a, input sample_b, input sample_c,
                    output ready);
endinterface

### rtl/core/ssms_result_if.sv
// Result channel: median, spread, next servo angle and stored medians.
interface ssms_result_if;
    logic              valid;
    logic              ready;
    ssms_pkg::pos_t    measured_position;
    ssms_pkg::range_t  median_distance;
    ssms_pkg::spread_t spread_variance;
    ssms_pkg::angle_t  servo_angle;
    ssms_pkg::range_t  range_pos0;
    ssms_pkg::range_t  range_pos1;
    ssms_pkg::range_t  range_pos2;

    modport source (output valid, output measured_position, output median_distance,
                    output spread_variance, output servo_angle, output range_pos0,
                    output range_pos1, output range_pos2, input ready);
    modport sink   (input valid, input measured_position, input median_distance,
                    input spread_variance, input servo_angle, input range_pos0,
                    input range_pos1, input range_pos2, output ready);
endinterface

### rtl/core/ssms_cfg_if.sv
// Configuration write channel: register index and write data.
interface ssms_cfg_if;
    logic               valid;
    logic               ready;
    ssms_pkg::cfg_idx_t index;
    ssms_pkg::angle_t   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/sonar_sweep_median_spread_top.sv
// Sonar sweep median/spread: top level with the full datapath.
//
// Channels: samples (sink) takes three range samples per transaction,
// results (source) gives one result per accepted transaction, cfg (sink)
// writes the three servo angle registers and is always ready.
// Datapath: input register, mean stage, squared-deviation stage, then a
// divide-by-three on the squared sum into the result register. The scan
// phase and the stored medians update when an item enters the result
// register, so results come out in acceptance order.
// Throughput: one transaction per cycle, set by the four-register pipeline
// that advances every cycle the result register is free or being taken.
// Stall: when results.ready is low the pipeline fills; samples.ready drops
// only once every stage holds an item.
// Reset: pipeline empties, scan phase returns to position zero, stored
// medians clear, servo angles go to 120, 90 and 60 degrees.
`include "assert_macros.svh"

module sonar_sweep_median_spread_top #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic           clk,
    input  logic           rst_n,
    ssms_sample_if.sink    samples,
    ssms_result_if.source  results,
    ssms_cfg_if.sink       cfg
);

    localparam int SB          = SAMPLE_BITS;
    localparam int SUM_W       = SB + 2;
    localparam int MEAN_SHIFT  = SUM_W + 2;
    localparam int MEAN_M_W    = SUM_W + 1;
    localparam int MEAN_PROD_W = SUM_W + MEAN_M_W;
    localparam int SQ_W        = 2 * SB;
    localparam int SP_SUM_W    = SQ_W + 2;
    localparam int SP_SHIFT    = SP_SUM_W + 2;
    localparam int SP_M_W      = SP_SUM_W + 1;
    localparam int SP_PROD_W   = SP_SUM_W + SP_M_W;
    localparam logic [MEAN_M_W-1:0] MEAN_RECIP =
        MEAN_M_W'((64'd1 << MEAN_SHIFT) / 64'd3);
    localparam logic [SP_M_W-1:0] SP_RECIP =
        SP_M_W'((64'd1 << SP_SHIFT) / 64'd3);

    // Pipeline flow control
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, res_vld_reg;
    logic out_free, s3_free, s2_free, s1_free, in_fire, s3_go;

    assign out_free      = !res_vld_reg || results.ready;
    assign s3_free       = !s3_vld_reg || out_free;
    assign s2_free       = !s2_vld_reg || s3_free;
    assign s1_free       = !s1_vld_reg || s2_free;
    assign samples.ready = s1_free;
    assign in_fire       = samples.valid && s1_free;
    assign s3_go         = s3_vld_reg && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_vld_reg <= samples.valid;
            if (s2_free)
                s2_vld_reg <= s1_vld_reg;
            if (s3_free)
                s3_vld_reg <= s2_vld_reg;
            if (out_free)
                res_vld_reg <= s3_vld_reg;
        end
    end

    // Stage 1: input register
    logic [SB-1:0] s1_a_reg, s1_b_reg, s1_c_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_a_reg <= samples.sample_a;
            s1_b_reg <= samples.sample_b;
            s1_c_reg <= samples.sample_c;
        end
    end

    // Truncated mean by reciprocal multiply plus one correction step
    logic [SUM_W-1:0]       s1_sum;
    logic [MEAN_PROD_W-1:0] s1_mean_prod;
    logic [SB-1:0]          s1_mean_est;
    logic [SUM_W-1:0]       s1_mean_rem;
    logic [SB-1:0]          s1_mean;

    assign s1_sum       = SUM_W'(s1_a_reg) + SUM_W'(s1_b_reg) + SUM_W'(s1_c_reg);
    assign s1_mean_prod = MEAN_PROD_W'(s1_sum) * MEAN_PROD_W'(MEAN_RECIP);
    assign s1_mean_est  = SB'(s1_mean_prod >> MEAN_SHIFT);
    assign s1_mean_rem  = s1_sum - (SUM_W'(s1_mean_est) + (SUM_W'(s1_mean_est) << 1));
    assign s1_mean      = (s1_mean_rem >= SUM_W'(ssms_pkg::SAMPLE_COUNT))
                          ? s1_mean_est + SB'(1) : s1_mean_est;

    // Median of three: max(min(a,b), min(max(a,b),c))
    logic [SB-1:0] s1_lo, s1_hi, s1_mid, s1_median;

    assign s1_lo     = (s1_a_reg > s1_b_reg) ? s1_b_reg : s1_a_reg;
    assign s1_hi     = (s1_a_reg > s1_b_reg) ? s1_a_reg : s1_b_reg;
    assign s1_mid    = (s1_hi > s1_c_reg) ? s1_c_reg : s1_hi;
    assign s1_median = (s1_lo > s1_mid) ? s1_lo : s1_mid;

    // Stage 2: samples, mean and median
    logic [SB-1:0] s2_a_reg, s2_b_reg, s2_c_reg, s2_mean_reg, s2_median_reg;

    always_ff @(posedge clk)
    begin
        if (s1_vld_reg && s2_free)
        begin
            s2_a_reg      <= s1_a_reg;
            s2_b_reg      <= s1_b_reg;
            s2_c_reg      <= s1_c_reg;
            s2_mean_reg   <= s1_mean;
            s2_median_reg <= s1_median;
        end
    end

    // Squared deviations from the mean
    logic [SB-1:0]       s2_dev_a, s2_dev_b, s2_dev_c;
    logic [SQ_W-1:0]     s2_sq_a, s2_sq_b, s2_sq_c;
    logic [SP_SUM_W-1:0] s2_sq_sum;

    assign s2_dev_a  = (s2_a_reg >= s2_mean_reg) ? s2_a_reg - s2_mean_reg
                                                 : s2_mean_reg - s2_a_reg;
    assign s2_dev_b  = (s2_b_reg >= s2_mean_reg) ? s2_b_reg - s2_mean_reg
                                                 : s2_mean_reg - s2_b_reg;
    assign s2_dev_c  = (s2_c_reg >= s2_mean_reg) ? s2_c_reg - s2_mean_reg
                                                 : s2_mean_reg - s2_c_reg;
    assign s2_sq_a   = SQ_W'(s2_dev_a) * SQ_W'(s2_dev_a);
    assign s2_sq_b   = SQ_W'(s2_dev_b) * SQ_W'(s2_dev_b);
    assign s2_sq_c   = SQ_W'(s2_dev_c) * SQ_W'(s2_dev_c);
    assign s2_sq_sum = SP_SUM_W'(s2_sq_a) + SP_SUM_W'(s2_sq_b) + SP_SUM_W'(s2_sq_c);

    // Stage 3: squared sum and median
    logic [SP_SUM_W-1:0] s3_sq_sum_reg;
    logic [SB-1:0]       s3_median_reg;

    always_ff @(posedge clk)
    begin
        if (s2_vld_reg && s3_free)
        begin
            s3_sq_sum_reg <= s2_sq_sum;
            s3_median_reg <= s2_median_reg;
        end
    end

    // Spread: squared sum over three, reciprocal multiply plus correction
    logic [SP_PROD_W-1:0] s3_sp_prod;
    logic [SQ_W-1:0]      s3_sp_est;
    logic [SP_SUM_W-1:0]  s3_sp_rem;
    logic [SQ_W-1:0]      s3_spread;

    assign s3_sp_prod = SP_PROD_W'(s3_sq_sum_reg) * SP_PROD_W'(SP_RECIP);
    assign s3_sp_est  = SQ_W'(s3_sp_prod >> SP_SHIFT);
    assign s3_sp_rem  = s3_sq_sum_reg
                        - (SP_SUM_W'(s3_sp_est) + (SP_SUM_W'(s3_sp_est) << 1));
    assign s3_spread  = (s3_sp_rem >= SP_SUM_W'(ssms_pkg::SAMPLE_COUNT))
                        ? s3_sp_est + SQ_W'(1) : s3_sp_est;

    // Scan position, median store and servo angle lookup
    ssms_pkg::phase_t phase_reg, phase_next;
    ssms_pkg::pos_t   cur_pos, next_pos;
    ssms_pkg::range_t med_trunc;
    ssms_pkg::range_t median_store_reg  [ssms_pkg::NUM_POS];
    ssms_pkg::range_t median_store_next [ssms_pkg::NUM_POS];
    ssms_pkg::angle_t angle_reg         [ssms_pkg::NUM_POS];

    assign phase_next = phase_reg + 2'd1;
    assign cur_pos    = ssms_pkg::phase_to_pos(phase_reg);
    assign next_pos   = ssms_pkg::phase_to_pos(phase_next);
    assign med_trunc  = ssms_pkg::RANGE_W'(s3_median_reg);

    always_comb
    begin
        for (int i = 0; i < ssms_pkg::NUM_POS; i++)
        begin
            median_store_next[i] = (cur_pos == ssms_pkg::POS_W'(i)) ? med_trunc
                                                                    : median_store_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            for (int i = 0; i < ssms_pkg::NUM_POS; i++)
            begin
                median_store_reg[i] <= '0;
            end
        end
        else if (s3_go)
        begin
            phase_reg <= phase_next;
            for (int i = 0; i < ssms_pkg::NUM_POS; i++)
            begin
                median_store_reg[i] <= median_store_next[i];
            end
        end
    end

    // Configuration writes; indexes past the last register are dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg[ssms_pkg::POS_ZERO] <= ssms_pkg::ANGLE_POS0_RESET;
            angle_reg[ssms_pkg::POS_ONE]  <= ssms_pkg::ANGLE_POS1_RESET;
            angle_reg[ssms_pkg::POS_TWO]  <= ssms_pkg::ANGLE_POS2_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                ssms_pkg::CFG_ANGLE_POS0: angle_reg[ssms_pkg::POS_ZERO] <= cfg.data;
                ssms_pkg::CFG_ANGLE_POS1: angle_reg[ssms_pkg::POS_ONE]  <= cfg.data;
                ssms_pkg::CFG_ANGLE_POS2: angle_reg[ssms_pkg::POS_TWO]  <= cfg.data;
                default: ;
            endcase
        end
    end

    // Result register
    ssms_pkg::pos_t    res_pos_reg;
    ssms_pkg::range_t  res_median_reg;
    ssms_pkg::spread_t res_spread_reg;
    ssms_pkg::angle_t  res_angle_reg;
    ssms_pkg::range_t  res_range0_reg, res_range1_reg, res_range2_reg;

    always_ff @(posedge clk)
    begin
        if (s3_go)
        begin
            res_pos_reg    <= cur_pos;
            res_median_reg <= med_trunc;
            res_spread_reg <= ssms_pkg::SPREAD_W'(s3_spread);
            res_angle_reg  <= angle_reg[next_pos];
            res_range0_reg <= median_store_next[ssms_pkg::POS_ZERO];
            res_range1_reg <= median_store_next[ssms_pkg::POS_ONE];
            res_range2_reg <= median_store_next[ssms_pkg::POS_TWO];
        end
    end

    assign results.valid             = res_vld_reg;
    assign results.measured_position = res_pos_reg;
    assign results.median_distance   = res_median_reg;
    assign results.spread_variance   = res_spread_reg;
    assign results.servo_angle       = res_angle_reg;
    assign results.range_pos0        = res_range0_reg;
    assign results.range_pos1        = res_range1_reg;
    assign results.range_pos2        = res_range2_reg;

    // Checks
    `ASSERT_NEXT(a_phase_step, clk, rst_n, s3_go, phase_reg == ssms_pkg::phase_t'($past(phase_reg) + 2'd1))
    `ASSERT_ALWAYS(a_own_range, clk, rst_n, !results.valid || results.measured_position != ssms_pkg::POS_ZERO || results.range_pos0 == results.median_distance)
    `ASSERT_NEXT(a_s2_hold, clk, rst_n, s2_vld_reg && !s3_free, s2_vld_reg && $stable(s2_median_reg))

endmodule

### bench/sonar_sweep_median_spread_top_tb.sv
// Testbench for the sonar sweep median/spread block: stimulus, prediction and checking.
`timescale 1ns / 1ps

module sonar_sweep_median_spread_top_tb;

    localparam int SAMPLE_BITS      = 12;
    localparam int CLK_HALF         = 10;
    localparam int RESET_CYCLES     = 12;
    localparam int PIPE_LATENCY     = 3;
    localparam int SETTLE_CYCLES    = PIPE_LATENCY + 3;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int RANDOM_PER_PHASE = 130;
    localparam int SAMPLE_TOP       = (1 << SAMPLE_BITS) - 1;

    // Index past the last angle register; writes to it must be dropped
    localparam ssms_pkg::cfg_idx_t CFG_IDX_SPARE = 2'd3;

    // Angle values at the edges of the legal range and beyond it
    localparam ssms_pkg::angle_t ANGLE_MIN      = 8'd0;
    localparam ssms_pkg::angle_t ANGLE_MAX      = 8'd180;
    localparam ssms_pkg::angle_t ANGLE_OVER     = 8'd181;
    localparam ssms_pkg::angle_t ANGLE_ALL_ONES = 8'd255;

    // One result transaction as seen on the result channel
    typedef struct packed {
        ssms_pkg::pos_t    pos;
        ssms_pkg::range_t  median;
        ssms_pkg::spread_t spread;
        ssms_pkg::angle_t  servo;
        ssms_pkg::range_t  r0;
        ssms_pkg::range_t  r1;
        ssms_pkg::range_t  r2;
    } sweep_result_t;

    // Predicts sweep results and checks them in acceptance order
    class sweep_scoreboard;
        ssms_pkg::angle_t angle_tbl[ssms_pkg::NUM_POS];
        ssms_pkg::range_t median_tbl[ssms_pkg::NUM_POS];
        ssms_pkg::phase_t phase;
        sweep_result_t    pending_q[$];
        int               mismatches;
        int               checked;

        function new();
            angle_tbl[ssms_pkg::POS_ZERO]  = ssms_pkg::ANGLE_POS0_RESET;
            angle_tbl[ssms_pkg::POS_ONE]   = ssms_pkg::ANGLE_POS1_RESET;
            angle_tbl[ssms_pkg::POS_TWO]   = ssms_pkg::ANGLE_POS2_RESET;
            median_tbl[ssms_pkg::POS_ZERO] = '0;
            median_tbl[ssms_pkg::POS_ONE]  = '0;
            median_tbl[ssms_pkg::POS_TWO]  = '0;
            phase                          = '0;
            mismatches                     = 0;
            checked                        = 0;
        endfunction

        // Ping-pong sweep: the last phase returns to the middle position
        function ssms_pkg::pos_t pos_of(ssms_pkg::phase_t ph);
            ssms_pkg::pos_t p;
            case (ph)
                ssms_pkg::PHASE_RETURN: p = ssms_pkg::POS_ONE;
                default:                p = ssms_pkg::pos_t'(ph);
            endcase
            return p;
        endfunction

        function longint unsigned sq_dev(longint unsigned v, longint unsigned m);
            longint unsigned d;
            d = (v >= m) ? (v - m) : (m - v);
            return d * d;
        endfunction

        // Out-of-range indexes are dropped
        function void set_angle(ssms_pkg::cfg_idx_t idx, ssms_pkg::angle_t val);
            if (idx < ssms_pkg::NUM_POS)
                angle_tbl[idx] = val;
        endfunction

        function int pending_count();
            return pending_q.size();
        endfunction

        // Work out the result caused by one accepted sample transaction
        function void note_samples(ssms_pkg::range_t a, ssms_pkg::range_t b,
                                   ssms_pkg::range_t c);
            longint unsigned  ua, ub, uc, mean, sq_sum;
            ssms_pkg::range_t mid;
            ssms_pkg::pos_t   here;
            sweep_result_t    want;
            ua     = a;
            ub     = b;
            uc     = c;
            mean   = (ua + ub + uc) / 3;
            sq_sum = sq_dev(ua, mean) + sq_dev(ub, mean) + sq_dev(uc, mean);
            if (a > b)
                mid = (b > c) ? b : ((a > c) ? c : a);
            else
                mid = (a > c) ? a : ((b > c) ? c : b);
            here             = pos_of(phase);
            median_tbl[here] = mid;
            phase            = phase + 2'd1;
            want.pos    = here;
            want.median = mid;
            want.spread = ssms_pkg::spread_t'(sq_sum / 3);
            want.servo  = angle_tbl[pos_of(phase)];
            want.r0     = median_tbl[ssms_pkg::POS_ZERO];
            want.r1     = median_tbl[ssms_pkg::POS_ONE];
            want.r2     = median_tbl[ssms_pkg::POS_TWO];
            pending_q.push_back(want);
        endfunction

        // One line per mismatch, and a running count
        task report_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        task cmp_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
                                          checked, name, got, want));
        endtask

        task check_result(sweep_result_t got);
            sweep_result_t want;
            if (pending_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result: pos %0d median %0d",
                                          got.pos, got.median));
            end
            else
            begin
                want = pending_q.pop_front();
                cmp_field("measured_position", 64'(got.pos), 64'(want.pos));
                cmp_field("median_distance", 64'(got.median), 64'(want.median));
                cmp_field("spread_variance", 64'(got.spread), 64'(want.spread));
                cmp_field("servo_angle", 64'(got.servo), 64'(want.servo));
                cmp_field("range_pos0", 64'(got.r0), 64'(want.r0));
                cmp_field("range_pos1", 64'(got.r1), 64'(want.r1));
                cmp_field("range_pos2", 64'(got.r2), 64'(want.r2));
                checked++;
            end
        endtask

        task flush_leftovers();
            sweep_result_t want;
            while (pending_q.size() > 0)
            begin
                want = pending_q.pop_front();
                report_mismatch($sformatf("result never arrived: pos %0d median %0d",
                                          want.pos, want.median));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    ssms_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch();
    ssms_result_if result_ch();
    ssms_cfg_if    cfg_ch();

    sonar_sweep_median_spread_top #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    sweep_scoreboard sb = new();

    sweep_result_t seen;

    int sender_idle_pct = 0;
    int sink_stall_pct  = 0;
    int items_sent      = 0;
    int directed_sent   = 0;
    int cfg_writes      = 0;
    int quiet_cycles    = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Result receiver: random back-pressure
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Transaction monitor: predict on input, check on output, track config
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_ch.valid && sample_ch.ready)
                sb.note_samples(sample_ch.sample_a, sample_ch.sample_b, sample_ch.sample_c);
            if (cfg_ch.valid && cfg_ch.ready)
                sb.set_angle(cfg_ch.index, cfg_ch.data);
            if (result_ch.valid && result_ch.ready)
            begin
                seen.pos    = result_ch.measured_position;
                seen.median = result_ch.median_distance;
                seen.spread = result_ch.spread_variance;
                seen.servo  = result_ch.servo_angle;
                seen.r0     = result_ch.range_pos0;
                seen.r1     = result_ch.range_pos1;
                seen.r2     = result_ch.range_pos2;
                sb.check_result(seen);
            end
        end
    end

    // Watchdog: ends the run if no channel moves for too long
    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // Present one sample transaction; entered and left at a falling edge
    task automatic send_samples(input ssms_pkg::range_t a, input ssms_pkg::range_t b,
                                input ssms_pkg::range_t c);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid    <= 1'b1;
        sample_ch.sample_a <= a;
        sample_ch.sample_b <= b;
        sample_ch.sample_c <= c;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Stop sending and wait until every pending result has been taken
    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        while (sb.pending_count() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // One register write; valid stays up so writes can run back to back
    task automatic write_angle(input ssms_pkg::cfg_idx_t idx, input ssms_pkg::angle_t val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_writes++;
        @(negedge clk);
    endtask

    task automatic cfg_release();
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly legal angles, now and then one past the servo range
    function automatic ssms_pkg::angle_t pick_angle();
        ssms_pkg::angle_t v;
        if ($urandom_range(9) == 0)
            v = ssms_pkg::angle_t'($urandom_range(255, 181));
        else
            v = ssms_pkg::angle_t'($urandom_range(180, 0));
        return v;
    endfunction

    task automatic random_config();
        write_angle(ssms_pkg::CFG_ANGLE_POS0, pick_angle());
        write_angle(ssms_pkg::CFG_ANGLE_POS1, pick_angle());
        write_angle(ssms_pkg::CFG_ANGLE_POS2, pick_angle());
        write_angle(CFG_IDX_SPARE, ssms_pkg::angle_t'($urandom_range(255)));
        cfg_release();
    endtask

    // Sample close to a base value, clamped to the field range
    function automatic ssms_pkg::range_t near(ssms_pkg::range_t base);
        int v;
        v = int'(base) + int'($urandom_range(16)) - 8;
        if (v < 0)
            v = 0;
        if (v > SAMPLE_TOP)
            v = SAMPLE_TOP;
        return ssms_pkg::range_t'(v);
    endfunction

    // Random sample triples in several shapes
    task automatic send_random();
        ssms_pkg::range_t a, b, c, base;
        int               shape;
        shape = $urandom_range(9);
        base  = ssms_pkg::range_t'($urandom_range(SAMPLE_TOP));
        a     = ssms_pkg::range_t'($urandom_range(SAMPLE_TOP));
        b     = ssms_pkg::range_t'($urandom_range(SAMPLE_TOP));
        c     = ssms_pkg::range_t'($urandom_range(SAMPLE_TOP));
        case (shape)
            5:
            begin
                a = near(base);
                b = near(base);
                c = near(base);
            end
            6:
            begin
                b = a;
            end
            7:
            begin
                a = $urandom_range(1) ? ssms_pkg::range_t'(SAMPLE_TOP) : '0;
                b = $urandom_range(1) ? ssms_pkg::range_t'(SAMPLE_TOP) : '0;
                c = $urandom_range(1) ? ssms_pkg::range_t'(SAMPLE_TOP) : '0;
            end
            8:
            begin
                a = base;
                b = base;
                c = base;
            end
            9:
            begin
                a = ssms_pkg::range_t'($urandom_range(15));
                b = ssms_pkg::range_t'($urandom_range(15));
                c = ssms_pkg::range_t'($urandom_range(15));
            end
            default: ;
        endcase
        send_samples(a, b, c);
    endtask

    task automatic run_random(input int count, input int idle_pct, input int stall_pct);
        sender_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        repeat (count) send_random();
    endtask

    // Main sequence
    initial
    begin
        rst_n              = 1'b0;
        sample_ch.valid    = 1'b0;
        sample_ch.sample_a = '0;
        sample_ch.sample_b = '0;
        sample_ch.sample_c = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = '0;
        cfg_ch.data        = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, orderings, ties; reset angles, several phase wraps
        send_samples(12'd0, 12'd0, 12'd0);
        send_samples(12'd4095, 12'd4095, 12'd4095);
        send_samples(12'd0, 12'd0, 12'd4095);
        send_samples(12'd4095, 12'd4095, 12'd0);
        send_samples(12'd0, 12'd4095, 12'd2048);
        send_samples(12'd100, 12'd2000, 12'd3000);
        send_samples(12'd100, 12'd3000, 12'd2000);
        send_samples(12'd2000, 12'd100, 12'd3000);
        send_samples(12'd2000, 12'd3000, 12'd100);
        send_samples(12'd3000, 12'd100, 12'd2000);
        send_samples(12'd3000, 12'd2000, 12'd100);
        send_samples(12'd5, 12'd5, 12'd4000);
        send_samples(12'd4000, 12'd5, 12'd5);
        send_samples(12'd5, 12'd4000, 12'd5);
        send_samples(12'hAAA, 12'h555, 12'hFFF);
        send_samples(12'h555, 12'hAAA, 12'h000);
        send_samples(12'd1, 12'd2, 12'd1);
        send_samples(12'd4094, 12'd1, 12'd2047);
        directed_sent = items_sent;
        drain_results();

        // Angle extremes, an out-of-range angle, a write to the unused index
        write_angle(ssms_pkg::CFG_ANGLE_POS0, ANGLE_MIN);
        write_angle(ssms_pkg::CFG_ANGLE_POS1, ANGLE_MAX);
        write_angle(ssms_pkg::CFG_ANGLE_POS2, ANGLE_ALL_ONES);
        write_angle(CFG_IDX_SPARE, ANGLE_MAX);
        cfg_release();
        run_random(RANDOM_PER_PHASE, 0, 0);
        drain_results();

        // Sender idles often
        random_config();
        run_random(RANDOM_PER_PHASE, 60, 0);
        drain_results();

        // Receiver stalls often
        write_angle(ssms_pkg::CFG_ANGLE_POS0, ANGLE_MAX);
        write_angle(ssms_pkg::CFG_ANGLE_POS1, ANGLE_MIN);
        write_angle(ssms_pkg::CFG_ANGLE_POS2, ANGLE_OVER);
        cfg_release();
        run_random(RANDOM_PER_PHASE, 0, 60);
        drain_results();

        // Both sides idle; sender pauses mid-phase until all results are in
        random_config();
        run_random(RANDOM_PER_PHASE / 2, 35, 35);
        drain_results();
        run_random(RANDOM_PER_PHASE - RANDOM_PER_PHASE / 2, 35, 35);
        drain_results();

        sb.flush_leftovers();
        $display("Run covered %0d sample transactions (%0d directed) and checked %0d results.",
                 items_sent, directed_sent, sb.checked);
        $display("%0d angle writes, incl. out-of-range angles and the unused index; %0d errors.",
                 cfg_writes, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
